>>> hdl/pidc_pkg.sv
`timescale 1ns / 1ps

package pidc_pkg;

  localparam int DATA_W        = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;

  typedef logic signed [DATA_W-1:0] word_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TIME_STEP  = 3'd0,
    REG_OUTPUT_MAX = 3'd1,
    REG_OUTPUT_MIN = 3'd2,
    REG_GAIN_P     = 3'd3,
    REG_GAIN_I     = 3'd4,
    REG_GAIN_D     = 3'd5
  } cfg_reg_t;

endpackage

>>> hdl/pidc_div.sv
`timescale 1ns / 1ps

module pidc_div
  import pidc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  input  word_t numer,
  input  word_t denom,
  output logic  done,
  output word_t quotient
);

  localparam int NUM_W = DATA_W + FRAC_BITS;
  localparam int CNT_W = $clog2(NUM_W);

  logic [NUM_W-1:0]  num_q;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dabs;
  logic              neg;
  logic              zero;
  logic              running;
  logic              fixup;
  logic [CNT_W-1:0]  cnt;

  logic [DATA_W:0]   shifted;
  logic [DATA_W+1:0] trial;
  logic              qbit;
  logic [DATA_W-1:0] nabs;
  logic [DATA_W-1:0] qlow;

  // Restoring division on magnitudes, one quotient bit per cycle. Quotient
  // bits shift into the bottom of the numerator register as it empties.
  always_comb begin
    shifted = {rem, num_q[NUM_W-1]};
    trial   = {1'b0, shifted} - {2'b00, dabs};
    qbit    = !trial[DATA_W+1];
    nabs    = numer[DATA_W-1] ? DATA_W'(-numer) : DATA_W'(numer);
    qlow    = num_q[DATA_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      fixup   <= 1'b0;
      done    <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      fixup   <= 1'b0;
      done    <= 1'b0;
    end else if (running) begin
      if (cnt == CNT_W'(NUM_W - 1)) begin
        running <= 1'b0;
        fixup   <= 1'b1;
      end
    end else if (fixup) begin
      fixup <= 1'b0;
      done  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_q <= {nabs, {FRAC_BITS{1'b0}}};
      rem   <= '0;
      dabs  <= denom[DATA_W-1] ? DATA_W'(-denom) : DATA_W'(denom);
      neg   <= numer[DATA_W-1] ^ denom[DATA_W-1];
      zero  <= (denom == '0);
      cnt   <= '0;
    end else if (running) begin
      num_q <= {num_q[NUM_W-2:0], qbit};
      rem   <= qbit ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      cnt   <= cnt + 1'b1;
    end else if (fixup) begin
      // Only the low word of the quotient is kept, so the sign fix is 32 bits wide.
      if (zero) begin
        quotient <= '0;
      end else if (neg) begin
        quotient <= word_t'(-qlow);
      end else begin
        quotient <= word_t'(qlow);
      end
    end
  end

endmodule

>>> hdl/fixed_point_pid_controller_unit.sv
// Discrete PID controller on signed Q16.16 samples (FRAC_BITS fraction bits). Each transfer on
// the sample channel carries a setpoint and a measurement and yields one clamped drive value.
// The unit works on one sample at a time and holds sample_stall until it is back in idle. A
// single bit-serial multiplier forms the four gain and time-step products one after another,
// one multiplier bit per cycle. The derivative division runs in a bit-serial divider alongside
// the first products. A finished drive value waits in an output register, so the next sample
// can be taken while it is held.
// Configuration writes take effect at once and are meant for times when no sample is in work.
`timescale 1ns / 1ps

module fixed_point_pid_controller_unit
  import pidc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 sample_valid,
  output logic                 sample_stall,
  input  word_t                target_value,
  input  word_t                measured_value,
  output logic                 drive_valid,
  input  logic                 drive_stall,
  output word_t                drive_value,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_data
);

  localparam int MCNT_W = $clog2(DATA_W);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_DIFF = 6'b000010,
    ST_MUL  = 6'b000100,
    ST_MEND = 6'b001000,
    ST_SUM  = 6'b010000,
    ST_OUT  = 6'b100000
  } state_t;

  typedef enum logic [1:0] {
    OP_P     = 2'd0,
    OP_INTEG = 2'd1,
    OP_I     = 2'd2,
    OP_D     = 2'd3
  } op_t;

  state_t state, state_next;
  op_t    op, op_next;

  word_t time_step, output_max, output_min, gain_p, gain_i, gain_d;
  word_t integral_sum, last_error;
  word_t err, diff, p_term, i_term, total;

  // Multiplier: upper partial product in acc, multiplier bits leave lo as product bits enter.
  word_t              mcand;
  logic signed [DATA_W:0] acc;
  logic [DATA_W-1:0]  lo;
  logic [MCNT_W-1:0]  mcnt;

  logic                     mul_last;
  logic signed [DATA_W+1:0] acc_x, mc_x, step_sum;
  logic [2*DATA_W-1:0]      product;
  word_t                    prod_q;
  word_t                    integ_next;
  word_t                    clamped;

  logic  mul_load;
  word_t load_a, load_b;
  logic  out_load;
  logic  div_start;
  logic  div_done;
  word_t div_quo;

  pidc_div #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .numer   (diff),
    .denom   (time_step),
    .done    (div_done),
    .quotient(div_quo)
  );

  always_comb begin
    mul_last = (mcnt == MCNT_W'(DATA_W - 1));
    acc_x    = {acc[DATA_W], acc};
    mc_x     = {{2{mcand[DATA_W-1]}}, mcand};
    // The top multiplier bit has negative weight, so the last step subtracts.
    if (!lo[0]) begin
      step_sum = acc_x;
    end else if (mul_last) begin
      step_sum = acc_x - mc_x;
    end else begin
      step_sum = acc_x + mc_x;
    end
    product    = {acc[DATA_W-1:0], lo};
    prod_q     = word_t'(product[FRAC_BITS +: DATA_W]);
    integ_next = integral_sum + prod_q;

    if (total > output_max) begin
      clamped = output_max;
    end else if (total < output_min) begin
      clamped = output_min;
    end else begin
      clamped = total;
    end
  end

  assign sample_stall = (state != ST_IDLE);
  assign out_load     = (state == ST_OUT) && (!drive_valid || !drive_stall);

  always_comb begin
    state_next = state;
    op_next    = op;
    mul_load   = 1'b0;
    load_a     = gain_p;
    load_b     = err;
    case (state)
      ST_IDLE: begin
        if (sample_valid) state_next = ST_DIFF;
      end
      ST_DIFF: begin
        mul_load   = 1'b1;
        load_a     = gain_p;
        load_b     = err;
        op_next    = OP_P;
        state_next = ST_MUL;
      end
      ST_MUL: begin
        if (mul_last) state_next = ST_MEND;
      end
      ST_MEND: begin
        case (op)
          OP_P: begin
            mul_load   = 1'b1;
            load_a     = err;
            load_b     = time_step;
            op_next    = OP_INTEG;
            state_next = ST_MUL;
          end
          OP_INTEG: begin
            mul_load   = 1'b1;
            load_a     = gain_i;
            load_b     = integ_next;
            op_next    = OP_I;
            state_next = ST_MUL;
          end
          OP_I: begin
            // The derivative product waits until the divider has its quotient.
            if (div_done) begin
              mul_load   = 1'b1;
              load_a     = gain_d;
              load_b     = div_quo;
              op_next    = OP_D;
              state_next = ST_MUL;
            end
          end
          OP_D: begin
            state_next = ST_SUM;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SUM: begin
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (!drive_valid || !drive_stall) state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      op           <= OP_P;
      div_start    <= 1'b0;
      drive_valid  <= 1'b0;
      time_step    <= '0;
      output_max   <= '0;
      output_min   <= '0;
      gain_p       <= '0;
      gain_i       <= '0;
      gain_d       <= '0;
      integral_sum <= '0;
      last_error   <= '0;
    end else begin
      state     <= state_next;
      op        <= op_next;
      div_start <= (state == ST_DIFF);
      if (state == ST_DIFF) last_error <= err;
      if (state == ST_MEND && op == OP_INTEG) integral_sum <= integ_next;
      if (out_load) begin
        drive_valid <= 1'b1;
      end else if (!drive_stall) begin
        drive_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_reg_t'(cfg_index))
          REG_TIME_STEP:  time_step  <= word_t'(cfg_data);
          REG_OUTPUT_MAX: output_max <= word_t'(cfg_data);
          REG_OUTPUT_MIN: output_min <= word_t'(cfg_data);
          REG_GAIN_P:     gain_p     <= word_t'(cfg_data);
          REG_GAIN_I:     gain_i     <= word_t'(cfg_data);
          REG_GAIN_D:     gain_d     <= word_t'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && sample_valid) err <= target_value - measured_value;
    if (state == ST_DIFF) diff <= err - last_error;
    if (state == ST_MEND && op == OP_P) p_term <= prod_q;
    if (state == ST_MEND && op == OP_I) i_term <= prod_q;
    if (state == ST_SUM) total <= p_term + i_term + prod_q;
    if (out_load) drive_value <= clamped;

    if (mul_load) begin
      mcand <= load_a;
      lo    <= DATA_W'(load_b);
      acc   <= '0;
      mcnt  <= '0;
    end else if (state == ST_MUL) begin
      acc  <= step_sum[DATA_W+1:1];
      lo   <= {step_sum[0], lo[DATA_W-1:1]};
      mcnt <= mcnt + 1'b1;
    end
  end

endmodule

>>> hdl/pidc_checker.sv
`timescale 1ns / 1ps

module pidc_checker
  import pidc_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  sample_valid,
  input logic  sample_stall,
  input logic  drive_valid,
  input logic  drive_stall,
  input word_t drive_value
);

  // A held result stays put until it is taken.
  a_drive_hold: assert property (@(posedge clk) disable iff (rst)
    drive_valid && drive_stall |=> drive_valid && $stable(drive_value))
    else $error("drive value changed or dropped while stalled");

  // Only one sample is in work at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    sample_valid && !sample_stall |=> sample_stall)
    else $error("sample channel open right after a transfer");

  // A new result appears only as the unit returns to idle.
  a_result_then_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(drive_valid) |-> !sample_stall)
    else $error("result appeared while a sample was still in work");

  a_reset_state: assert property (@(posedge clk)
    rst |=> !drive_valid && !sample_stall)
    else $error("unit not idle after reset");

endmodule

bind fixed_point_pid_controller_unit pidc_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .drive_valid (drive_valid),
  .drive_stall (drive_stall),
  .drive_value (drive_value)
);

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import pidc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_CYCLES = 150;
  localparam int RANDOM_PHASES = 16;
  localparam int ITEMS_PER_PHASE = 118;

  localparam word_t W_MAX = 32'sh7fff_ffff;
  localparam word_t W_MIN = 32'sh8000_0000;
  localparam word_t W_ONE = 32'sh0001_0000;

  // Indexes past the last register; writes to them must leave every register alone.
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;

  typedef struct {
    word_t target;
    word_t measured;
  } sample_t;

  logic                 clk;
  logic                 rst;
  logic                 sample_valid;
  logic                 sample_stall;
  word_t                target_value;
  word_t                measured_value;
  logic                 drive_valid;
  logic                 drive_stall;
  word_t                drive_value;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0]    cfg_data;

  fixed_point_pid_controller_unit dut (
    .clk            (clk),
    .rst            (rst),
    .sample_valid   (sample_valid),
    .sample_stall   (sample_stall),
    .target_value   (target_value),
    .measured_value (measured_value),
    .drive_valid    (drive_valid),
    .drive_stall    (drive_stall),
    .drive_value    (drive_value),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  // Controller copy: registers and loop state.
  word_t dt_reg, max_reg, min_reg, kp_reg, ki_reg, kd_reg;
  word_t integ_acc, prev_err;

  sample_t pending_samples[$];
  word_t   expected_drive[$];
  int      items_queued;
  int      items_accepted;
  int      mismatch_count;
  int      cycle_count;
  bit      steady;
  bit      sample_done;
  int      send_gap;
  int      stall_left;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic word_t q_mul(word_t a, word_t b);
    logic signed [63:0] wa, wb, prod;
    wa = a;
    wb = b;
    prod = (wa * wb) >>> FRAC;
    return prod[31:0];
  endfunction

  // Quotient truncates toward zero; a zero divisor gives zero.
  function automatic word_t q_div(word_t a, word_t b);
    logic signed [63:0] num, den, quo;
    if (b == 0) return '0;
    num = a;
    num = num <<< FRAC;
    den = b;
    quo = num / den;
    return quo[31:0];
  endfunction

  function automatic word_t pid_predict(word_t target, word_t measured);
    word_t err, p_term, i_term, d_term, deriv, sum;
    err = target - measured;
    p_term = q_mul(kp_reg, err);
    integ_acc = integ_acc + q_mul(err, dt_reg);
    i_term = q_mul(ki_reg, integ_acc);
    deriv = q_div(err - prev_err, dt_reg);
    d_term = q_mul(kd_reg, deriv);
    sum = p_term + i_term + d_term;
    // When the limits are crossed, a sum above the upper limit gives the upper limit and any other sum the lower limit.
    if (sum > max_reg) sum = max_reg;
    else if (sum < min_reg) sum = min_reg;
    prev_err = err;
    return sum;
  endfunction

  // Mostly short, now and then a long one.
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  function automatic word_t pick_extreme();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 32'sd1;
      2: return -32'sd1;
      3: return W_MAX;
      4: return W_MIN;
      5: return W_ONE;
      default: return -W_ONE;
    endcase
  endfunction

  // Uniform over about -8.0 .. +8.0.
  function automatic word_t small_signed();
    return word_t'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
  endfunction

  task automatic report(string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      REG_TIME_STEP:  dt_reg = value;
      REG_OUTPUT_MAX: max_reg = value;
      REG_OUTPUT_MIN: min_reg = value;
      REG_GAIN_P:     kp_reg = value;
      REG_GAIN_I:     ki_reg = value;
      REG_GAIN_D:     kd_reg = value;
      default: ;
    endcase
  endtask

  task automatic load_config(word_t dt, word_t hi, word_t lo, word_t kp, word_t ki, word_t kd);
    write_reg(REG_TIME_STEP, dt);
    write_reg(REG_OUTPUT_MAX, hi);
    write_reg(REG_OUTPUT_MIN, lo);
    write_reg(REG_GAIN_P, kp);
    write_reg(REG_GAIN_I, ki);
    write_reg(REG_GAIN_D, kd);
  endtask

  task automatic end_writes();
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic enqueue(word_t target, word_t measured);
    sample_t s;
    s.target = target;
    s.measured = measured;
    pending_samples.push_back(s);
    items_queued++;
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (items_accepted != items_queued || expected_drive.size() != 0);
  endtask

  // Sample driver: a new transfer is offered only once the previous one went through.
  always @(negedge clk) begin
    sample_t s;
    if (rst) begin
      sample_valid <= 1'b0;
      send_gap = 0;
    end else if (!(sample_valid && !sample_done)) begin
      if (send_gap > 0) begin
        sample_valid <= 1'b0;
        send_gap--;
      end else if (pending_samples.size() > 0) begin
        s = pending_samples.pop_front();
        sample_valid   <= 1'b1;
        target_value   <= s.target;
        measured_value <= s.measured;
        send_gap = steady ? 0 : pick_len();
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Drive receiver back-pressure.
  always @(negedge clk) begin
    if (rst || steady) begin
      drive_stall <= 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      drive_stall <= 1'b1;
      stall_left--;
    end else begin
      drive_stall <= 1'b0;
      stall_left = pick_len();
    end
  end

  // Monitor: predicts on every sample transfer and checks every drive transfer.
  always @(posedge clk) begin
    word_t want;
    if (rst) begin
      sample_done <= 1'b0;
    end else begin
      sample_done <= sample_valid && !sample_stall;
      if (sample_valid && !sample_stall) begin
        expected_drive.push_back(pid_predict(target_value, measured_value));
        items_accepted++;
      end
      if (drive_valid && !drive_stall) begin
        if (expected_drive.size() == 0) begin
          report($sformatf("drive transfer %h with no sample outstanding", drive_value));
        end else begin
          want = expected_drive.pop_front();
          if (drive_value !== want)
            report($sformatf("drive_value %h, expected %h", drive_value, want));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    word_t t, m, dt, hi, lo, kp, ki, kd;
    int n;
    rst = 1'b1;
    sample_valid = 1'b0;
    target_value = '0;
    measured_value = '0;
    drive_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    steady = 1'b0;
    dt_reg = '0; max_reg = '0; min_reg = '0;
    kp_reg = '0; ki_reg = '0; kd_reg = '0;
    integ_acc = '0; prev_err = '0;
    items_queued = 0;
    items_accepted = 0;
    mismatch_count = 0;
    cycle_count = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Unit P gain, full clamp range, field extremes and error wrap.
    load_config(W_ONE, W_MAX, W_MIN, W_ONE, 32'sh0000_8000, 32'sh0000_4000);
    end_writes();
    enqueue(0, 0);
    enqueue(W_ONE, 0);
    enqueue(W_MAX, W_MIN);
    enqueue(W_MIN, W_MAX);
    enqueue(W_MAX, 0);
    enqueue(W_MIN, 0);
    enqueue(0, W_MIN);
    enqueue(-32'sd1, 0);
    enqueue(32'sh0003_0000, W_ONE);
    wait_idle();

    // A zero time step must yield no derivative term.
    load_config(0, W_MAX, W_MIN, 32'sh0002_0000, W_ONE, 32'sh0003_0000);
    end_writes();
    enqueue(32'sh0005_0000, 0);
    enqueue(0, 32'sh0005_0000);
    enqueue(32'sh1234_5678, 0);
    wait_idle();

    // Upper limit below lower limit.
    load_config(W_ONE, -32'sh0005_0000, 32'sh0005_0000, W_ONE, 0, 0);
    end_writes();
    enqueue(32'sh0010_0000, 0);
    enqueue(-32'sh0010_0000, 0);
    enqueue(0, 0);
    wait_idle();

    // Extreme registers; writes past the last register are dropped.
    load_config(W_MIN, W_MAX, W_MIN, W_MAX, W_MIN, W_MAX);
    write_reg(IDX_SPARE_LO, W_ONE);
    write_reg(IDX_SPARE_HI, -32'sd1);
    end_writes();
    enqueue(W_MAX, W_MIN);
    enqueue(W_MIN, W_MAX);
    enqueue(32'sd1, 0);
    wait_idle();

    load_config(-32'sd1, W_MAX, W_MIN, -W_ONE, 32'sd1, W_MIN);
    end_writes();
    enqueue(32'sh7fff_0000, 0);
    enqueue(0, 32'sd1);
    enqueue(0, 0);
    wait_idle();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      steady = (phase % 4 == 1);
      case ($urandom_range(0, 4))
        0: begin
          dt = $urandom_range(1, 32'h0002_0000);
          hi = $urandom_range(32'h0001_0000, 32'h7fff_ffff);
          lo = word_t'(0) - word_t'($urandom_range(32'h0001_0000, 32'h7fff_ffff));
          kp = small_signed(); ki = small_signed(); kd = small_signed();
        end
        1: begin
          dt = $urandom; hi = $urandom; lo = $urandom;
          kp = $urandom; ki = $urandom; kd = $urandom;
        end
        2: begin
          dt = pick_extreme(); hi = pick_extreme(); lo = pick_extreme();
          kp = pick_extreme(); ki = pick_extreme(); kd = pick_extreme();
        end
        3: begin
          dt = pick_extreme(); hi = $urandom; lo = $urandom;
          kp = small_signed(); ki = small_signed(); kd = small_signed();
        end
        default: begin
          dt = 0;
          hi = $urandom_range(32'h0001_0000, 32'h7fff_ffff);
          lo = word_t'(0) - word_t'($urandom_range(32'h0001_0000, 32'h7fff_ffff));
          kp = small_signed(); ki = small_signed(); kd = small_signed();
        end
      endcase
      load_config(dt, hi, lo, kp, ki, kd);
      if ($urandom_range(0, 2) == 0)
        write_reg($urandom_range(0, 1) ? IDX_SPARE_LO : IDX_SPARE_HI, $urandom);
      end_writes();

      for (n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Odd phases hold the sender halfway until the pipeline has drained.
        if (n == ITEMS_PER_PHASE / 2 && phase % 2 == 1)
          wait_idle();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: begin
            // A process that tracks its setpoint closely.
            t = word_t'($urandom_range(0, 32'h0040_0000)) - 32'sh0020_0000;
            m = t + word_t'($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
          end
          6, 7: begin
            t = $urandom;
            m = $urandom;
          end
          8: begin
            t = pick_extreme();
            m = pick_extreme();
          end
          default: begin
            t = $urandom;
            m = t;
          end
        endcase
        enqueue(t, m);
      end
      wait_idle();
    end
    steady = 1'b0;

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (expected_drive.size() != 0)
      report($sformatf("%0d drive values never arrived", expected_drive.size()));
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
